[rtl/pbd_pkg.sv]
// Shared types and constants of the pushbutton edge debouncer.
package pbd_pkg;

   localparam int ACTION_W = 2;
   localparam int PIN_W    = 3;
   localparam int COUNT_W  = 16;

   // Number of pins that the pin field can address.
   localparam int PIN_SPACE = 1 << PIN_W;

   localparam logic [COUNT_W-1:0] LOCKOUT_RESET = 16'd20;

   localparam logic [ACTION_W-1:0] ACTION_DC        = 2'd0;
   localparam logic [ACTION_W-1:0] ACTION_AC_EDGE   = 2'd1;
   localparam logic [ACTION_W-1:0] ACTION_AC_EXPIRY = 2'd2;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [PIN_W-1:0]    pin;
      logic                level;
      logic                edge_select;
   } pbd_item_type;

   // Per-pin state and latch updates decided for one item.
   typedef struct packed {
      logic               flag;
      logic               count_we;
      logic [COUNT_W-1:0] count_next;
      logic               prev_we;
      logic               prev_next;
      logic               latch_pin_we;
      logic               latch_edge_we;
   } pbd_update_type;

endpackage

[rtl/pbd_req_if.sv]
// Input channel of the debouncer: one sampling tick of one pin per item.
interface pbd_req_if;
   logic                         valid;
   logic                         ready;
   logic [pbd_pkg::ACTION_W-1:0] action;
   logic [pbd_pkg::PIN_W-1:0]    pin;
   logic                         level;
   logic                         edge_select;

   modport source (output valid, action, pin, level, edge_select, input ready);
   modport sink   (input valid, action, pin, level, edge_select, output ready);
endinterface

[rtl/pbd_rsp_if.sv]
// Result channel of the debouncer: event flag and latched pin and edge.
interface pbd_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      event_res;
   logic [pbd_pkg::PIN_W-1:0] event_pin;
   logic                      event_edge;

   modport source (output valid, event_res, event_pin, event_edge, input ready);
   modport sink   (input valid, event_res, event_pin, event_edge, output ready);
endinterface

[rtl/pbd_input_stage.sv]
// Input register of the debouncer with its valid flag and ready logic.
module pbd_input_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  pbd_pkg::pbd_item_type in_item,
   input  logic                  advance,
   output logic                  item_valid,
   output pbd_pkg::pbd_item_type item
);
   import pbd_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   pbd_item_type item_ff;

   // The register takes a new item when it is empty or its item moves on.
   assign in_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;
endmodule

[rtl/pbd_pin_logic.sv]
// Lockout and edge decision for one pin tick in the dc and ac modes.
module pbd_pin_logic (
   input  pbd_pkg::pbd_item_type       item,
   input  logic                        pin_active,
   input  logic [pbd_pkg::COUNT_W-1:0] count,
   input  logic                        prev,
   input  logic [pbd_pkg::COUNT_W-1:0] lockout_ticks,
   output pbd_pkg::pbd_update_type     update
);
   import pbd_pkg::*;

   logic               sel_edge;
   logic               locked;
   logic [COUNT_W-1:0] count_dec;

   assign sel_edge  = (item.level == item.edge_select) && (prev != item.edge_select);
   assign locked    = (count != '0);
   assign count_dec = count - COUNT_W'(1);

   always_comb begin
      update = '0;
      update.prev_next = item.level;
      if (pin_active) begin
         case (item.action)
            ACTION_DC: begin
               if (locked) begin
                  // The level is not tracked while the dc lockout runs.
                  update.count_we   = 1'b1;
                  update.count_next = count_dec;
               end else begin
                  update.prev_we = 1'b1;
                  if (item.level != prev) begin
                     update.flag          = 1'b1;
                     update.latch_pin_we  = 1'b1;
                     update.latch_edge_we = 1'b1;
                     update.count_we      = 1'b1;
                     update.count_next    = lockout_ticks;
                  end
               end
            end
            ACTION_AC_EDGE, ACTION_AC_EXPIRY: begin
               update.prev_we = 1'b1;
               if (locked) begin
                  // A selected edge restarts the lockout; expiry is still seen.
                  update.count_we   = 1'b1;
                  update.count_next = sel_edge ? lockout_ticks : count_dec;
                  update.flag       = (item.action == ACTION_AC_EXPIRY) && (count_dec == '0);
               end else if (sel_edge) begin
                  update.count_we     = 1'b1;
                  update.count_next   = lockout_ticks;
                  update.latch_pin_we = 1'b1;
                  update.flag         = (item.action == ACTION_AC_EDGE);
               end
            end
            default: begin
               update.prev_we = 1'b0;
            end
         endcase
      end
   end
endmodule

[rtl/pushbutton_edge_debouncer_core.sv]
// Top level of the pushbutton edge debouncer: pin state, latches and result register.
//
// Each item on req_if is one sampling tick of one pin: its mode (action), pin
// index, sampled level and, for the ac modes, the edge to watch. Every item
// gives exactly one item on rsp_if: the event flag for that tick and the pin
// and edge latched at the most recent accepted edge, as they stand after it.
// The user must write the lockout length through csr_wr_en and csr_wr_data only
// while the block is idle; the block does not enforce this. It resets to 20 ticks.
// An item is registered on acceptance and evaluated from the input register
// against the per-pin lockout timer and previous level, which are updated at the
// same edge that loads the result register. One item is taken every cycle while
// the result register is not held: the state of a pin is read and written back
// at the edge that retires its item, so an item for the same pin right behind
// sees the updated state.
// When rsp_if.ready is low the result register holds, the input register
// fills, and req_if.ready falls once both are occupied.
// Synchronous reset empties both registers and clears all timers, previous
// levels, the latched pin and edge, and reloads the lockout length.
// Pins at or above PIN_COUNT and the unused mode change no state.
module pushbutton_edge_debouncer_core #(
   parameter int PIN_COUNT = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   pbd_req_if.sink                     req_if,
   pbd_rsp_if.source                   rsp_if,
   input  logic                        csr_wr_en,
   input  logic [pbd_pkg::COUNT_W-1:0] csr_wr_data
);
   import pbd_pkg::*;

   // Only pins that the pin field can address get storage.
   localparam int DEPTH = (PIN_COUNT < PIN_SPACE) ? PIN_COUNT : PIN_SPACE;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [COUNT_W-1:0] lockout_ticks_ff;

   logic [COUNT_W-1:0] count_ff [DEPTH];
   logic               prev_ff  [DEPTH];
   logic [PIN_W-1:0]   latched_pin_ff;
   logic               latched_edge_ff;
   logic [PIN_W-1:0]   latched_pin_in;
   logic               latched_edge_in;

   logic               res_valid_ff;
   logic               res_valid_in;
   logic               res_flag_ff;
   logic [PIN_W-1:0]   res_pin_ff;
   logic               res_edge_ff;

   pbd_item_type       in_item;
   pbd_item_type       item;
   logic               item_valid;
   logic               advance;
   logic               pin_active;
   logic [IDX_W-1:0]   pin_idx;
   logic [COUNT_W-1:0] count_cur;
   logic               prev_cur;
   logic               fire;
   pbd_update_type     update;

   assign in_item.action      = req_if.action;
   assign in_item.pin         = req_if.pin;
   assign in_item.level       = req_if.level;
   assign in_item.edge_select = req_if.edge_select;

   // The evaluated item moves into the result register once that is free.
   assign advance = !res_valid_ff || rsp_if.ready;
   assign fire    = item_valid && advance;

   pbd_input_stage u_input_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_if.valid),
      .in_ready   (req_if.ready),
      .in_item    (in_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   // Out-of-range pins never index the state; they read entry zero harmlessly.
   assign pin_active = (32'(item.pin) < PIN_COUNT);
   assign pin_idx    = pin_active ? item.pin[IDX_W-1:0] : '0;
   assign count_cur  = count_ff[pin_idx];
   assign prev_cur   = prev_ff[pin_idx];

   pbd_pin_logic u_pin_logic (
      .item          (item),
      .pin_active    (pin_active),
      .count         (count_cur),
      .prev          (prev_cur),
      .lockout_ticks (lockout_ticks_ff),
      .update        (update)
   );

   always_comb begin
      latched_pin_in  = latched_pin_ff;
      latched_edge_in = latched_edge_ff;
      if (update.latch_pin_we) begin
         latched_pin_in = item.pin;
      end
      if (update.latch_edge_we) begin
         latched_edge_in = item.level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lockout_ticks_ff <= LOCKOUT_RESET;
      end else if (csr_wr_en) begin
         lockout_ticks_ff <= csr_wr_data;
      end
   end

   // Per-pin timers and previous levels, written back as each item retires.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            count_ff[i] <= '0;
            prev_ff[i]  <= 1'b0;
         end
         latched_pin_ff  <= '0;
         latched_edge_ff <= 1'b0;
      end else if (fire) begin
         if (update.count_we) begin
            count_ff[pin_idx] <= update.count_next;
         end
         if (update.prev_we) begin
            prev_ff[pin_idx] <= update.prev_next;
         end
         latched_pin_ff  <= latched_pin_in;
         latched_edge_ff <= latched_edge_in;
      end
   end

   always_comb begin
      res_valid_in = res_valid_ff;
      if (advance) begin
         res_valid_in = item_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else begin
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         res_flag_ff <= update.flag;
         res_pin_ff  <= latched_pin_in;
         res_edge_ff <= latched_edge_in;
      end
   end

   assign rsp_if.valid      = res_valid_ff;
   assign rsp_if.event_res  = res_flag_ff;
   assign rsp_if.event_pin  = res_pin_ff;
   assign rsp_if.event_edge = res_edge_ff;
endmodule

[bench/pbd_check_pkg.sv]
// Result predictor and scoreboard for the pushbutton edge debouncer testbench.
`timescale 1ns / 100ps

package pbd_check_pkg;
   import pbd_pkg::*;

   typedef struct packed {
      logic             event_res;
      logic [PIN_W-1:0] event_pin;
      logic             event_edge;
   } debounce_event_type;

   class debounce_predictor;
      int                 pin_limit;
      logic [COUNT_W-1:0] lockout_ticks;
      logic [COUNT_W-1:0] lockout_timer [PIN_SPACE];
      logic               last_level [PIN_SPACE];
      logic [PIN_W-1:0]   latched_pin;
      logic               latched_edge;
      debounce_event_type pending_events [$];
      int                 mismatch_count;

      function new(int pins);
         pin_limit      = pins;
         lockout_ticks  = LOCKOUT_RESET;
         latched_pin    = '0;
         latched_edge   = 1'b0;
         mismatch_count = 0;
         for (int i = 0; i < PIN_SPACE; i++) begin
            lockout_timer[i] = '0;
            last_level[i]    = 1'b0;
         end
      endfunction

      function void set_lockout(logic [COUNT_W-1:0] ticks);
         lockout_ticks = ticks;
      endfunction

      function int pending();
         return pending_events.size();
      endfunction

      // Advances the state of one pin by one accepted tick and queues its result.
      function void note_tick(logic [ACTION_W-1:0] action, logic [PIN_W-1:0] pin,
                              logic level, logic edge_select);
         logic               flag;
         logic               watched_edge;
         debounce_event_type expected;
         flag = 1'b0;
         if (action <= ACTION_AC_EXPIRY && int'(pin) < pin_limit) begin
            watched_edge = (level == edge_select) && (last_level[pin] != edge_select);
            if (action == ACTION_DC) begin
               if (lockout_timer[pin] != '0) begin
                  lockout_timer[pin] = lockout_timer[pin] - 1'b1;
               end else begin
                  if (level != last_level[pin]) begin
                     flag               = 1'b1;
                     latched_edge       = level;
                     latched_pin        = pin;
                     lockout_timer[pin] = lockout_ticks;
                  end
                  last_level[pin] = level;
               end
            end else if (lockout_timer[pin] != '0) begin
               // Locked in an ac mode: the level is still tracked and a watched
               // edge restarts the lockout without touching the latches.
               lockout_timer[pin] = lockout_timer[pin] - 1'b1;
               if (action == ACTION_AC_EXPIRY && lockout_timer[pin] == '0) begin
                  flag = 1'b1;
               end
               if (watched_edge) begin
                  lockout_timer[pin] = lockout_ticks;
               end
               last_level[pin] = level;
            end else begin
               if (watched_edge) begin
                  lockout_timer[pin] = lockout_ticks;
                  latched_pin        = pin;
                  if (action == ACTION_AC_EDGE) begin
                     flag = 1'b1;
                  end
               end
               last_level[pin] = level;
            end
         end
         expected.event_res  = flag;
         expected.event_pin  = latched_pin;
         expected.event_edge = latched_edge;
         pending_events.push_back(expected);
      endfunction

      function void check_event(logic event_res, logic [PIN_W-1:0] event_pin,
                                logic event_edge);
         debounce_event_type expected;
         if (pending_events.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result res=%0d pin=%0d edge=%0d", $time,
                     event_res, event_pin, event_edge);
            return;
         end
         expected = pending_events.pop_front();
         if (event_res !== expected.event_res) begin
            mismatch_count++;
            $display("%0t: event_res expected %0d actual %0d", $time,
                     expected.event_res, event_res);
         end
         if (event_pin !== expected.event_pin) begin
            mismatch_count++;
            $display("%0t: event_pin expected %0d actual %0d", $time,
                     expected.event_pin, event_pin);
         end
         if (event_edge !== expected.event_edge) begin
            mismatch_count++;
            $display("%0t: event_edge expected %0d actual %0d", $time,
                     expected.event_edge, event_edge);
         end
      endfunction

      function void report_leftovers();
         if (pending_events.size() != 0) begin
            mismatch_count++;
            $display("%0t: %0d expected results never arrived", $time,
                     pending_events.size());
         end
      endfunction
   endclass

endpackage

[bench/pushbutton_edge_debouncer_core_test.sv]
// Top-level testbench of the pushbutton edge debouncer core.
`timescale 1ns / 100ps

module pushbutton_edge_debouncer_core_test;
   import pbd_pkg::*;
   import pbd_check_pkg::*;

   localparam int PIN_COUNT = 8;

   // The fourth encoding of the action field is not a mode; the block ignores it.
   localparam logic [ACTION_W-1:0] ACTION_UNUSED = 2'd3;

   // Watchdog limit; it leaves room above the slowest correct run,
   // including the long receiver hold-offs.
   localparam int CYCLE_LIMIT = 400000;

   // Extra cycles after the last result to catch spurious output items.
   localparam int TAIL_CYCLES = 12;

   // Length of the deliberate receiver hold-off, long enough to fill the block.
   localparam int HOLD_CYCLES = 120;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [COUNT_W-1:0] csr_wr_data;

   pbd_req_if req_if ();
   pbd_rsp_if rsp_if ();

   pushbutton_edge_debouncer_core #(
      .PIN_COUNT(PIN_COUNT)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .rsp_if     (rsp_if),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   debounce_predictor debounce_model;

   // Stimulus bookkeeping: the level each simulated button currently sits at,
   // and the mode and watched edge that each pin uses within a phase.
   logic            button_level [PIN_COUNT];
   logic [ACTION_W-1:0] pin_mode [PIN_COUNT];
   logic            pin_select [PIN_COUNT];

   int items_counted;
   int burst_left;
   int cycle_count;

   // The main process asks for a hold-off by bumping hold_requests; the
   // receiver process serves it and counts the held cycles itself.
   int hold_requests;
   int hold_served;
   int hold_left;
   int stall_style;
   int stall_window;
   int stall_phase;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Every input of the block starts at a known value.
   initial begin
      clock              = 1'b0;
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      req_if.valid       = 1'b0;
      req_if.action      = ACTION_DC;
      req_if.pin         = '0;
      req_if.level       = 1'b0;
      req_if.edge_select = 1'b0;
      rsp_if.ready       = 1'b0;
      hold_requests      = 0;
      hold_served        = 0;
      hold_left          = 0;
      stall_style        = 0;
      stall_window       = 0;
      stall_phase        = 0;
      cycle_count        = 0;
      debounce_model     = new(PIN_COUNT);
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Receiver. Ready changes at the falling edge. Outside a requested hold-off
   // it switches between styles in windows of random length: always ready,
   // coin-flip stalls, ready only when the phase counter is a multiple of four, and rare stalls.
   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served++;
         hold_left = HOLD_CYCLES - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         if (stall_window == 0) begin
            stall_style  = $urandom_range(0, 3);
            stall_window = $urandom_range(20, 100);
         end
         stall_window--;
         stall_phase++;
         case (stall_style)
            0: begin
               rsp_if.ready <= 1'b1;
            end
            1: begin
               rsp_if.ready <= 1'($urandom_range(0, 1));
            end
            2: begin
               rsp_if.ready <= (stall_phase % 4 == 0);
            end
            default: begin
               rsp_if.ready <= ($urandom_range(0, 4) != 0);
            end
         endcase
      end
   end

   // Each result item is compared at the rising edge where it is accepted.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         debounce_model.check_event(rsp_if.event_res, rsp_if.event_pin,
                                    rsp_if.event_edge);
      end
   end

   // Offers one item and returns at the rising edge that accepts it. Valid is
   // only raised here and only lowered in the gaps between bursts and in drain,
   // so it is never lowered and raised within one step.
   task automatic send_item(logic [ACTION_W-1:0] action, logic [PIN_W-1:0] pin,
                            logic level, logic edge_select);
      int gap;
      @(negedge clock);
      req_if.valid       <= 1'b1;
      req_if.action      <= action;
      req_if.pin         <= pin;
      req_if.level       <= level;
      req_if.edge_select <= edge_select;
      do begin
         @(posedge clock);
      end while (!req_if.ready);
      debounce_model.note_tick(action, pin, level, edge_select);
      if (action <= ACTION_AC_EXPIRY && int'(pin) < PIN_COUNT) begin
         items_counted++;
      end
      // The sender works in bursts; a gap follows each burst.
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(30, 60)
                                                : $urandom_range(1, 16);
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            @(negedge clock);
            req_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   // Stops offering items until every expected result has been received.
   task automatic drain();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (debounce_model.pending() != 0) @(negedge clock);
   endtask

   // Only called with the block idle: nothing offered, nothing outstanding.
   task automatic write_lockout(logic [COUNT_W-1:0] ticks);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= ticks;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      debounce_model.set_lockout(ticks);
   endtask

   // Directed checks with a two-tick lockout, so that every timer path shows
   // within a few ticks. Covers the ignored mode, both dc edges and the dc
   // lockout, the ac edge report and restart, expiry reporting another pin's
   // latch, and an expiry that coincides with a new watched edge.
   task automatic run_directed();
      send_item(ACTION_UNUSED, 3'd7, 1'b1, 1'b1);
      send_item(ACTION_DC, 3'd0, 1'b1, 1'b0);
      send_item(ACTION_DC, 3'd0, 1'b0, 1'b0);
      send_item(ACTION_DC, 3'd0, 1'b0, 1'b1);
      send_item(ACTION_DC, 3'd0, 1'b0, 1'b0);
      send_item(ACTION_DC, 3'd7, 1'b1, 1'b1);
      send_item(ACTION_AC_EDGE, 3'd1, 1'b1, 1'b1);
      send_item(ACTION_AC_EDGE, 3'd1, 1'b0, 1'b1);
      send_item(ACTION_AC_EDGE, 3'd1, 1'b1, 1'b1);
      send_item(ACTION_AC_EDGE, 3'd1, 1'b1, 1'b1);
      send_item(ACTION_AC_EXPIRY, 3'd2, 1'b0, 1'b0);
      send_item(ACTION_AC_EXPIRY, 3'd2, 1'b1, 1'b0);
      send_item(ACTION_AC_EXPIRY, 3'd2, 1'b0, 1'b0);
      send_item(ACTION_AC_EXPIRY, 3'd3, 1'b1, 1'b1);
      send_item(ACTION_AC_EXPIRY, 3'd2, 1'b0, 1'b0);
      send_item(ACTION_AC_EXPIRY, 3'd2, 1'b0, 1'b0);
      send_item(ACTION_AC_EXPIRY, 3'd3, 1'b0, 1'b1);
      send_item(ACTION_AC_EXPIRY, 3'd3, 1'b1, 1'b1);
      send_item(ACTION_AC_EXPIRY, 3'd3, 1'b1, 1'b1);
      send_item(ACTION_AC_EXPIRY, 3'd3, 1'b1, 1'b1);
      send_item(ACTION_UNUSED, 3'd4, 1'b0, 1'b0);
      send_item(ACTION_AC_EDGE, 3'd7, 1'b0, 1'b0);
      send_item(ACTION_AC_EDGE, 3'd7, 1'b1, 1'b0);
      send_item(ACTION_AC_EDGE, 3'd7, 1'b0, 1'b0);
   endtask

   // One button press on one pin: it bounces for the first third of the
   // sequence and then mostly settles. Now and then a tick of another pin is
   // slipped in, as a real scan of several buttons would do.
   task automatic run_press();
      int p;
      int q;
      int len;
      p   = $urandom_range(0, PIN_COUNT - 1);
      len = $urandom_range(4, 28);
      for (int k = 0; k < len; k++) begin
         if ($urandom_range(0, 99) < 12) begin
            q = $urandom_range(0, PIN_COUNT - 1);
            if ($urandom_range(0, 2) == 0) begin
               button_level[q] = !button_level[q];
            end
            send_item(pin_mode[q], q[PIN_W-1:0], button_level[q], pin_select[q]);
         end
         if ($urandom_range(0, 99) < ((k < len / 3) ? 50 : 8)) begin
            button_level[p] = !button_level[p];
         end
         send_item(pin_mode[p], p[PIN_W-1:0], button_level[p], pin_select[p]);
      end
   endtask

   // A run of random presses and noise under one lockout length. Halfway the
   // sender waits until every result is in; a hold-off may be requested at
   // the first third while the sender keeps offering items.
   task automatic run_phase(int count, bit with_hold);
      int start;
      bit paused;
      bit held;
      start  = items_counted;
      paused = 1'b0;
      held   = 1'b0;
      for (int i = 0; i < PIN_COUNT; i++) begin
         pin_mode[i]   = ACTION_W'($urandom_range(0, 2));
         pin_select[i] = 1'($urandom_range(0, 1));
      end
      while (items_counted - start < count) begin
         if (with_hold && !held && items_counted - start >= count / 3) begin
            held = 1'b1;
            hold_requests++;
         end
         if (!paused && items_counted - start >= count / 2) begin
            paused = 1'b1;
            drain();
         end
         if ($urandom_range(0, 99) < 85) begin
            run_press();
         end else begin
            // Noise: any field value, the ignored mode included, and now and
            // then a pin switched to another mode mid-lockout.
            if ($urandom_range(0, 3) == 0) begin
               pin_mode[$urandom_range(0, PIN_COUNT - 1)] = ACTION_W'($urandom_range(0, 2));
            end
            send_item(ACTION_W'($urandom_range(0, 3)), PIN_W'($urandom_range(0, 7)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end
      end
      drain();
   endtask

   initial begin
      items_counted = 0;
      burst_left    = 0;
      for (int i = 0; i < PIN_COUNT; i++) begin
         button_level[i] = 1'b0;
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // A first phase with the lockout length left at its reset value.
      run_phase(60, 1'b0);

      write_lockout(16'd2);
      run_directed();
      drain();

      // Lockout lengths: short, zero (no hold-off at all), one, the
      // maximum, and two random ones.
      write_lockout(16'd3);
      run_phase(125, 1'b1);
      write_lockout(16'd0);
      run_phase(110, 1'b0);
      write_lockout(16'd1);
      run_phase(125, 1'b0);
      write_lockout(16'hFFFF);
      run_phase(90, 1'b1);
      write_lockout(COUNT_W'($urandom_range(2, 12)));
      run_phase(140, 1'b0);
      write_lockout(COUNT_W'($urandom_range(13, 60)));
      run_phase(110, 1'b1);

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      debounce_model.report_leftovers();
      if (debounce_model.mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
